### rtl/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

   // Deepest pattern the scanner can hold. Pattern and mask registers cover
   // sixteen bytes; positions beyond them compare as wildcards.
   localparam int PatternMax   = 16;
   localparam int WinIdxWidth  = (PatternMax > 1) ? $clog2(PatternMax) : 1;
   localparam int ByteWidth    = 8;
   localparam int RegWidth     = 64;
   localparam int LenWidth     = 5;
   localparam int AddrWidth    = 48;
   localparam int OffsetWidth  = 32;
   localparam int CsrIdxWidth  = 3;
   localparam int BytesPerReg  = RegWidth / ByteWidth;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef byte_type [PatternMax-1:0] window_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_MASK_LOW       = 3'd2,
      CSR_MASK_HIGH      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_BASE_ADDRESS   = 3'd5,
      CSR_RESULT_OFFSET  = 3'd6
   } csr_index_type;

   // Byte k of a low/high register pair; bytes past the pair read as zero.
   function automatic byte_type reg_byte(input logic [RegWidth-1:0] lo,
                                         input logic [RegWidth-1:0] hi,
                                         input int k);
      byte_type b;
      b = '0;
      if (k < BytesPerReg) begin
         b = lo[ByteWidth*k +: ByteWidth];
      end else if (k < 2 * BytesPerReg) begin
         b = hi[ByteWidth*(k-BytesPerReg) +: ByteWidth];
      end
      return b;
   endfunction

endpackage

`default_nettype wire

### rtl/mbps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mbps_req_if;
   logic                            valid;
   logic                            ready;
   logic [mbps_pkg::ByteWidth-1:0]  data_byte;
   logic                            last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [mbps_pkg::AddrWidth-1:0]  match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

### rtl/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// The scanner takes one memory byte per clock cycle on the request channel,
// unless a stalled response channel holds it back, and looks for the first
// place in a region where the loaded pattern matches under its bit mask (zero
// mask bits are not compared). Every accepted byte shifts a sixteen-byte
// window and runs one parallel masked compare in the same cycle, so a
// transaction can be accepted in every cycle without such a stall; a result
// passes the compare stage register and then the output register, which takes
// the 48-bit address sum, on its way to the response channel. A region produces
// exactly one response: the first match, with address base plus start minus
// the signed offset (modulo 2^48), or a not-found response with address zero
// on the byte marked last. Later matches in the region are dropped, and the
// byte marked last restarts the scan. Configuration registers are written
// through the csr port and should only change while no transaction is in flight.
module masked_byte_pattern_scanner (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mbps_req_if.sink                                req_chan,
   mbps_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_write_enable,
   input  wire logic [mbps_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [mbps_pkg::RegWidth-1:0]      csr_write_data
);

   localparam int W  = mbps_pkg::WinIdxWidth;
   localparam int AW = mbps_pkg::AddrWidth;
   localparam int OW = mbps_pkg::OffsetWidth;

   // Configuration registers.
   logic [mbps_pkg::RegWidth-1:0] pattern_low_ff, pattern_high_ff;
   logic [mbps_pkg::RegWidth-1:0] mask_low_ff, mask_high_ff;
   logic [mbps_pkg::LenWidth-1:0] pattern_length_ff;
   logic [AW-1:0]                 base_address_ff;
   logic [OW-1:0]                 result_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         mask_low_ff       <= '0;
         mask_high_ff      <= '0;
         pattern_length_ff <= mbps_pkg::LenWidth'(1);
         base_address_ff   <= '0;
         result_offset_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (mbps_pkg::csr_index_type'(csr_index))
            mbps_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            mbps_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            mbps_pkg::CSR_MASK_LOW:       mask_low_ff       <= csr_write_data;
            mbps_pkg::CSR_MASK_HIGH:      mask_high_ff      <= csr_write_data;
            mbps_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_write_data[mbps_pkg::LenWidth-1:0];
            end
            mbps_pkg::CSR_BASE_ADDRESS:   base_address_ff   <= csr_write_data[AW-1:0];
            mbps_pkg::CSR_RESULT_OFFSET:  result_offset_ff  <= csr_write_data[OW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective length minus one: a length of zero acts as one, and anything
   // longer than the window is clamped to the window depth.
   logic [W-1:0] len_m1;
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_m1 = '0;
      end else if (int'(pattern_length_ff) > mbps_pkg::PatternMax) begin
         len_m1 = W'(mbps_pkg::PatternMax - 1);
      end else begin
         len_m1 = W'(pattern_length_ff - mbps_pkg::LenWidth'(1));
      end
   end

   // Region state: the window of recent bytes, the byte count and whether this
   // region has already been answered.
   mbps_pkg::window_type window_ff, window_in;
   logic [AW-1:0]        bytes_seen_ff, bytes_seen_in;
   logic                 reported_ff, reported_in;

   // Compare stage register and the output register.
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_found_ff, s1_found_in;
   logic [AW-1:0] s1_start_ff, s1_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 s1_move;
   mbps_pkg::window_type window_shift;
   logic [AW-1:0]        seen_next;
   logic [AW-1:0]        len_full;
   logic                 hit;
   logic                 hit_now;
   logic                 emit;

   // The response register frees up when it is empty or being drained; the
   // compare stage may then advance, and a new transaction may enter whenever
   // the compare stage is empty or advancing.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      window_shift[0] = req_chan.data_byte;
      for (int j = 1; j < mbps_pkg::PatternMax; j++) begin
         window_shift[j] = window_ff[j-1];
      end
   end

   assign seen_next = bytes_seen_ff + AW'(1);
   assign len_full  = AW'(len_m1) + AW'(1);

   mbps_match_unit u_match (
      .window       (window_shift),
      .pattern_low  (pattern_low_ff),
      .pattern_high (pattern_high_ff),
      .mask_low     (mask_low_ff),
      .mask_high    (mask_high_ff),
      .len_m1       (len_m1),
      .hit          (hit)
   );

   // Only the first match of a region counts, and only once enough bytes have
   // arrived to fill the pattern. A region ending unanswered gets not-found.
   assign hit_now = !reported_ff && (seen_next >= len_full) && hit;
   assign emit    = hit_now || (req_chan.last_byte && !reported_ff);

   always_comb begin
      window_in     = window_ff;
      bytes_seen_in = bytes_seen_ff;
      reported_in   = reported_ff;
      if (req_fire) begin
         if (req_chan.last_byte) begin
            window_in     = '0;
            bytes_seen_in = '0;
            reported_in   = 1'b0;
         end else begin
            window_in     = window_shift;
            bytes_seen_in = seen_next;
            reported_in   = reported_ff || hit_now;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_found_in = s1_found_ff;
      s1_start_in = s1_start_ff;
      if (req_fire && emit) begin
         s1_valid_in = 1'b1;
         s1_found_in = hit_now;
         s1_start_in = seen_next - len_full;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // The reported address is base plus start minus the sign-extended offset.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = s1_found_ff;
         if (s1_found_ff) begin
            rsp_addr_in = base_address_ff + s1_start_ff
                        - {{(AW-OW){result_offset_ff[OW-1]}}, result_offset_ff};
         end else begin
            rsp_addr_in = '0;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         bytes_seen_ff <= '0;
         reported_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_ff     <= window_in;
         bytes_seen_ff <= bytes_seen_in;
         reported_ff   <= reported_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_found_ff  <= s1_found_in;
      s1_start_ff  <= s1_start_in;
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.match_address = rsp_addr_ff;

endmodule

`default_nettype wire

### rtl/mbps_match_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Masked compare of the window against the active pattern bytes.
module mbps_match_unit (
   input  wire mbps_pkg::window_type            window,
   input  wire logic [mbps_pkg::RegWidth-1:0]   pattern_low,
   input  wire logic [mbps_pkg::RegWidth-1:0]   pattern_high,
   input  wire logic [mbps_pkg::RegWidth-1:0]   mask_low,
   input  wire logic [mbps_pkg::RegWidth-1:0]   mask_high,
   input  wire logic [mbps_pkg::WinIdxWidth-1:0] len_m1,
   output logic                                 hit
);

   localparam int W = mbps_pkg::WinIdxWidth;

   always_comb begin
      logic [W-1:0]        idx;
      mbps_pkg::byte_type  m;
      mbps_pkg::byte_type  p;
      mbps_pkg::byte_type  w;
      hit = 1'b1;
      for (int k = 0; k < mbps_pkg::PatternMax; k++) begin
         // Pattern byte k lines up with the byte seen len-1-k transactions ago.
         idx = len_m1 - W'(k);
         m   = mbps_pkg::reg_byte(mask_low, mask_high, k);
         p   = mbps_pkg::reg_byte(pattern_low, pattern_high, k);
         w   = window[idx];
         if ((int'(len_m1) >= k) && ((m & w) != (m & p))) begin
            hit = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire
